// File: design/lcgsm_pkg.sv
// shared constants and types for the lcg sparse mask generator
package lcgsm_pkg;

  localparam logic [63:0] LCG_MUL       = 64'd2862933555777941757;
  localparam logic [63:0] LCG_ADD       = 64'd3037000493;
  localparam logic [63:0] SEED_AT_RESET = 64'd42;

  localparam logic [1:0] KIND_DRAW64 = 2'd0;
  localparam logic [1:0] KIND_DRAW32 = 2'd1;
  localparam logic [1:0] KIND_MASK   = 2'd2;
  localparam logic [1:0] KIND_RESEED = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LL,
    PH_LH,
    PH_HL,
    PH_ACC,
    PH_ADD
  } adv_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_MOD,
    ST_OUT
  } ctrl_state_e;

endpackage

// File: design/lcgsm_mul.sv
// registered 32x32 unsigned multiplier shared by the generator step
module lcgsm_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: design/lcgsm_adv.sv
// one generator advance, x*A + B mod 2^64, as three partial products on one multiplier
module lcgsm_adv
  import lcgsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [63:0] y_o
);

  adv_phase_e  phase_q, phase_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] acc_q;

  lcgsm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_LL;
      PH_LL:   phase_d = PH_LH;
      PH_LH:   phase_d = PH_HL;
      PH_HL:   phase_d = PH_ACC;
      PH_ACC:  phase_d = PH_ADD;
      PH_ADD:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // operand selection and done flag; the product is registered and lands in the cycle after issue
  always_comb begin
    mul_a  = 32'd0;
    mul_b  = 32'd0;
    done_o = 1'b0;
    case (phase_q)
      PH_LL: begin
        mul_a = LCG_MUL[31:0];
        mul_b = x_i[31:0];
      end
      PH_LH: begin
        mul_a = LCG_MUL[31:0];
        mul_b = x_i[63:32];
      end
      PH_HL: begin
        mul_a = LCG_MUL[63:32];
        mul_b = x_i[31:0];
      end
      PH_ADD:  done_o = 1'b1;
      default: ;
    endcase
  end

  // only the low halves of the cross products reach the upper word
  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_LH:   acc_q <= prod;
      PH_HL:   acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      PH_ACC:  acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign y_o = acc_q + LCG_ADD;

endmodule

// File: design/lcgsm_idx.sv
// reduces the upper state word to a bit index modulo the mask width
module lcgsm_idx #(
  parameter int MASK_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   upper_i,
  output logic                          done_o,
  output logic [$clog2(MASK_WIDTH)-1:0] idx_o
);

  localparam int IDX_W = $clog2(MASK_WIDTH);

  generate
    if ((1 << IDX_W) == MASK_WIDTH) begin : g_pow2
      logic             done_q;
      logic [IDX_W-1:0] idx_q;

      always_ff @(posedge clk_i) begin
        if (start_i) idx_q <= upper_i[IDX_W-1:0];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start_i;
        end
      end

      assign done_o = done_q;
      assign idx_o  = idx_q;
    end else begin : g_fold
      // byte weights fold the word to 16 bits, a reciprocal multiply gives the
      // quotient and the remainder follows, one step per cycle
      localparam int          SHIFT = 16 + IDX_W;
      localparam logic [15:0] W1    = 16'((1 << 8) % MASK_WIDTH);
      localparam logic [15:0] W2    = 16'((1 << 16) % MASK_WIDTH);
      localparam logic [15:0] W3    = 16'((1 << 24) % MASK_WIDTH);
      localparam logic [17:0] RECIP = 18'(((1 << SHIFT) + MASK_WIDTH - 1) / MASK_WIDTH);

      logic             fold_vld_q, quot_vld_q, done_q;
      logic [15:0]      fold_q, fold_d;
      logic [15:0]      quot_q;
      logic [33:0]      quot_prod;
      logic [15:0]      rem_full;
      logic [IDX_W-1:0] rem_q;

      assign fold_d = 16'(upper_i[7:0])
                    + 16'(upper_i[15:8]) * W1
                    + 16'(upper_i[23:16]) * W2
                    + 16'(upper_i[31:24]) * W3;

      assign quot_prod = 34'(fold_q) * 34'(RECIP);
      assign rem_full  = fold_q - quot_q * 16'(MASK_WIDTH);

      always_ff @(posedge clk_i) begin
        if (start_i) fold_q <= fold_d;
        if (fold_vld_q) quot_q <= 16'(quot_prod >> SHIFT);
        if (quot_vld_q) rem_q <= rem_full[IDX_W-1:0];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          fold_vld_q <= 1'b0;
          quot_vld_q <= 1'b0;
          done_q     <= 1'b0;
        end else begin
          fold_vld_q <= start_i;
          quot_vld_q <= fold_vld_q;
          done_q     <= quot_vld_q;
        end
      end

      assign done_o = done_q;
      assign idx_o  = rem_q;
    end
  endgenerate

endmodule

// File: design/lcg_sparse_mask_generator.sv
// 64-bit linear congruential generator with random words and sparse bit masks
//
// Input channel: in_valid_i / in_stall_o carry kind_i, bit_count_i, seed_value_i.
// Output channel: out_valid_o / out_stall_i carry value_o.
// Kind 0 returns the advanced 64-bit state, kind 1 its upper 32 bits, kind 2 a
// mask of min(bit_count, MASK_WIDTH) distinct set bits, kind 3 loads seed_value
// and returns nothing (block stays ready).
// One request is worked on at a time; in_stall_o is high until its result is in
// the output register, and the next request can be taken in that same cycle.
// Each generator advance runs on the shared 32x32 multiplier through phases LL,
// LH, HL, ACC and ADD (three partial products, two accumulates, one add). For
// kinds 0 and 1 the advanced state goes to res_q and then to the output register.
// Kind 2 runs one advance per draw, then the index reduction (idx_q at a
// power-of-two width, fold_q, quot_q and rem_q otherwise), then loads the
// result; a zero count goes straight to the output. Rejected repeats add draws;
// a full 64-bit mask needs roughly 300 draws.
// The output register holds a finished result while out_stall_i is high; the
// next request may still be taken, and its result then waits, keeping
// in_stall_o high, until the register drains.
// Reset sets the generator state to 42 and clears the mask and output valid.
module lcg_sparse_mask_generator
  import lcgsm_pkg::*;
#(
  parameter int MASK_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [6:0]  bit_count_i,
  input  logic [63:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o
);

  localparam int CNT_W = $clog2(MASK_WIDTH + 1);
  localparam int IDX_W = $clog2(MASK_WIDTH);

  ctrl_state_e           state_q, state_d;
  logic [63:0]           gen_q, gen_d;
  logic [1:0]            kind_q, kind_d;
  logic [CNT_W-1:0]      target_q, target_d;
  logic [CNT_W-1:0]      placed_q, placed_d;
  logic [MASK_WIDTH-1:0] mask_q, mask_d;
  logic [63:0]           res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic [63:0]           value_q, value_d;

  logic                  in_accept, out_load;
  logic [CNT_W-1:0]      sat_count;
  logic                  adv_start, adv_done;
  logic [63:0]           adv_y;
  logic                  idx_start, idx_done;
  logic [IDX_W-1:0]      idx;
  logic                  bit_new;
  logic [CNT_W-1:0]      placed_inc;
  logic [MASK_WIDTH-1:0] mask_set;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign sat_count = (bit_count_i > 7'(MASK_WIDTH)) ? CNT_W'(MASK_WIDTH)
                                                     : bit_count_i[CNT_W-1:0];

  assign bit_new    = !mask_q[idx];
  assign placed_inc = placed_q + CNT_W'(bit_new);
  assign mask_set   = mask_q | (MASK_WIDTH'(bit_new) << idx);

  assign adv_start = (in_accept && (kind_i != KIND_RESEED)
                      && !((kind_i == KIND_MASK) && (sat_count == '0)))
                  || ((state_q == ST_MOD) && idx_done && (placed_inc != target_q));
  assign idx_start = (state_q == ST_ADV) && adv_done && (kind_q == KIND_MASK);

  lcgsm_adv u_adv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (adv_start),
    .x_i     (gen_q),
    .done_o  (adv_done),
    .y_o     (adv_y)
  );

  lcgsm_idx #(
    .MASK_WIDTH (MASK_WIDTH)
  ) u_idx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (idx_start),
    .upper_i (adv_y[63:32]),
    .done_o  (idx_done),
    .idx_o   (idx)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (kind_i == KIND_RESEED) state_d = ST_IDLE;
          else if ((kind_i == KIND_MASK) && (sat_count == '0)) state_d = ST_OUT;
          else state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        if (adv_done) state_d = (kind_q == KIND_MASK) ? ST_MOD : ST_OUT;
      end
      ST_MOD: begin
        if (idx_done) state_d = (placed_inc == target_q) ? ST_OUT : ST_ADV;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    gen_d    = gen_q;
    kind_d   = kind_q;
    target_d = target_q;
    placed_d = placed_q;
    mask_d   = mask_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_d = kind_i;
          if (kind_i == KIND_RESEED) begin
            gen_d = seed_value_i;
          end else if (kind_i == KIND_MASK) begin
            target_d = sat_count;
            placed_d = '0;
            mask_d   = '0;
            res_d    = '0;
          end
        end
      end
      ST_ADV: begin
        if (adv_done) begin
          gen_d = adv_y;
          if (kind_q == KIND_DRAW32) res_d = {32'd0, adv_y[63:32]};
          else res_d = adv_y;
        end
      end
      ST_MOD: begin
        if (idx_done) begin
          mask_d   = mask_set;
          placed_d = placed_inc;
          res_d    = 64'(mask_set);
        end
      end
      default: ;
    endcase
  end

  // output register: a new load wins over a drain in the same cycle
  always_comb begin
    value_d     = value_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      value_d     = res_q;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_d_hold: begin
      res_q   <= res_d;
      value_q <= value_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= SEED_AT_RESET;
      kind_q      <= KIND_DRAW64;
      target_q    <= '0;
      placed_q    <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      kind_q      <= kind_d;
      target_q    <= target_d;
      placed_q    <= placed_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

`ifndef SYNTH
  a_adv_done_in_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_done |-> (state_q == ST_ADV))
    else $error("generator step finished outside the advance state");

  a_mask_popcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mask_q) == int'(placed_q))
    else $error("mask population differs from placed bit count");

  a_placed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    placed_q <= target_q)
    else $error("more bits placed than requested");

  a_reseed_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (kind_i == KIND_RESEED)) |=> (gen_q == $past(seed_value_i)))
    else $error("reseed transaction did not load the generator state");
`endif

endmodule
